// File: hw/rtl/slcd_pkg.sv
// Shared types and constants of the sync/length/checksum deframer.
package slcd_pkg;

  // Input item codes.
  localparam logic MODE_BYTE = 1'b0;
  localparam logic MODE_TICK = 1'b1;

  // Result item codes.
  localparam logic KIND_PAYLOAD   = 1'b0;
  localparam logic KIND_FRAME_END = 1'b1;

  localparam logic [1:0] ST_OK       = 2'd0;
  localparam logic [1:0] ST_BAD_SUM  = 2'd1;
  localparam logic [1:0] ST_TOO_LONG = 2'd2;

  // Frame constants.
  localparam logic [7:0] SYNC_FIRST        = 8'h55;
  localparam logic [7:0] SYNC_SECOND       = 8'hAA;
  localparam logic [7:0] GAP_TIMEOUT_RESET = 8'd5;
  localparam logic [7:0] IDLE_MAX          = 8'hFF;

  typedef struct packed {
    logic       mode;
    logic [7:0] rx_byte;
  } in_item_t;

  typedef struct packed {
    logic        kind;
    logic [7:0]  payload_byte;
    logic [7:0]  command;
    logic [7:0]  version;
    logic [15:0] frame_length;
    logic [1:0]  status;
    logic        last;
  } out_item_t;

endpackage

// File: hw/rtl/slcd_in_if.sv
// Input channel of the deframer: received bytes and millisecond ticks.
interface slcd_in_if;
  logic               valid;
  logic               ready;
  slcd_pkg::in_item_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

// File: hw/rtl/slcd_out_if.sv
// Result channel of the deframer: payload bytes and frame-end summaries.
interface slcd_out_if;
  logic                valid;
  logic                ready;
  slcd_pkg::out_item_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

// File: hw/rtl/sync_length_checksum_deframer.sv
// Top level of the sync/length/checksum frame deframer.
//
// The deframer takes a stream of items, each either a received serial byte or a
// one millisecond tick, and recovers frames of the form 0x55, 0xAA, version,
// command, 16-bit big-endian length, payload and an additive checksum (the sum
// modulo 256 of every byte before it). Every payload byte leaves as a payload
// result as soon as it arrives; the checksum byte produces a frame-end result
// carrying command, version, length and a status of ok or bad checksum. A
// length above MAX_PAYLOAD produces a frame-end result with the too-long status
// right after the second length byte, and the search restarts. Ticks count idle
// time, saturating at 255; a byte arriving after more than gap_timeout ticks of
// silence restarts the frame search before that byte is handled. A bad second
// sync byte is dropped and the search restarts. The block accepts one item in
// every cycle: an item is captured in an input register, the frame state is
// updated in a single pass of short logic, and any result lands in an output
// register when its item leaves the input register. While a result waits there,
// one more item can be taken into the input register; the input then stalls
// until the waiting result has been transferred.
// gap_timeout is written through cfg_we/cfg_wdata and should only change while
// the block is idle.
module sync_length_checksum_deframer #(
  parameter int MAX_PAYLOAD = 256
) (
  input  logic             clk,
  input  logic             rst_n,
  slcd_in_if.sink          in_ch,
  slcd_out_if.source       out_ch,
  input  logic             cfg_we,
  input  logic [7:0]       cfg_wdata
);

  // Payload byte counter covers 0 .. MAX_PAYLOAD.
  localparam int          CNT_W   = (MAX_PAYLOAD < 2) ? 1 : $clog2(MAX_PAYLOAD + 1);
  localparam logic [15:0] MAX_LEN = 16'(MAX_PAYLOAD);

  // Position within the frame.
  typedef enum logic [2:0] {
    PH_HUNT,
    PH_SYNC2,
    PH_VERSION,
    PH_COMMAND,
    PH_LEN_HI,
    PH_LEN_LO,
    PH_PAYLOAD,
    PH_CHECKSUM
  } phase_t;

  // Configuration register.
  logic [7:0] gap_timeout_r;

  // Input register.
  logic               s1_valid_r;
  slcd_pkg::in_item_t s1_item_r;

  // Frame state.
  phase_t             phase_r, phase_nxt;
  logic [CNT_W-1:0]   count_r, count_nxt;
  logic [15:0]        length_r, length_nxt;
  logic [7:0]         sum_r, sum_nxt;
  logic [7:0]         command_r, command_nxt;
  logic [7:0]         version_r, version_nxt;
  logic [7:0]         idle_r, idle_nxt;

  // Result register.
  logic                out_valid_r;
  slcd_pkg::out_item_t out_item_r;

  logic                s1_advance;
  logic                res_valid;
  slcd_pkg::out_item_t res_item;

  // Effective state after a possible gap restart.
  logic               gap_restart;
  phase_t             phase_eff;
  logic [15:0]        length_eff;
  logic [7:0]         sum_eff;
  logic [7:0]         b;
  logic [7:0]         sum_add;
  logic [15:0]        len_full;

  // The item in the input register moves on when the result register is free
  // or is being emptied in this cycle.
  assign s1_advance  = s1_valid_r && (!out_valid_r || out_ch.ready);
  assign in_ch.ready = !s1_valid_r || s1_advance;

  assign out_ch.valid = out_valid_r;
  assign out_ch.data  = out_item_r;

  assign b           = s1_item_r.rx_byte;
  assign gap_restart = (idle_r > gap_timeout_r);
  assign phase_eff   = gap_restart ? PH_HUNT : phase_r;
  assign length_eff  = gap_restart ? 16'd0 : length_r;
  assign sum_eff     = gap_restart ? 8'd0 : sum_r;
  assign sum_add     = sum_eff + b;
  assign len_full    = {length_eff[15:8], b};

  always_comb begin
    phase_nxt   = phase_r;
    count_nxt   = count_r;
    length_nxt  = length_r;
    sum_nxt     = sum_r;
    command_nxt = command_r;
    version_nxt = version_r;
    idle_nxt    = idle_r;
    res_valid   = 1'b0;

    res_item.kind         = slcd_pkg::KIND_PAYLOAD;
    res_item.payload_byte = 8'd0;
    res_item.command      = command_r;
    res_item.version      = version_r;
    res_item.frame_length = length_eff;
    res_item.status       = slcd_pkg::ST_OK;
    res_item.last         = 1'b0;

    if (s1_advance) begin
      if (s1_item_r.mode == slcd_pkg::MODE_TICK) begin
        if (idle_r != slcd_pkg::IDLE_MAX) begin
          idle_nxt = idle_r + 8'd1;
        end
      end else begin
        idle_nxt   = 8'd0;
        phase_nxt  = phase_eff;
        length_nxt = length_eff;
        sum_nxt    = sum_eff;
        case (phase_eff)
          PH_HUNT: begin
            if (b == slcd_pkg::SYNC_FIRST) begin
              sum_nxt   = b;
              phase_nxt = PH_SYNC2;
            end
          end
          PH_SYNC2: begin
            if (b == slcd_pkg::SYNC_SECOND) begin
              sum_nxt   = sum_add;
              phase_nxt = PH_VERSION;
            end else begin
              // Dropped; not retried as a first sync byte.
              phase_nxt  = PH_HUNT;
              sum_nxt    = 8'd0;
              length_nxt = 16'd0;
            end
          end
          PH_VERSION: begin
            version_nxt = b;
            sum_nxt     = sum_add;
            phase_nxt   = PH_COMMAND;
          end
          PH_COMMAND: begin
            command_nxt = b;
            sum_nxt     = sum_add;
            phase_nxt   = PH_LEN_HI;
          end
          PH_LEN_HI: begin
            length_nxt = {b, 8'd0};
            sum_nxt    = sum_add;
            phase_nxt  = PH_LEN_LO;
          end
          PH_LEN_LO: begin
            count_nxt = '0;
            if (len_full > MAX_LEN) begin
              // Reported at once with the announced length, then restart.
              res_valid             = 1'b1;
              res_item.kind         = slcd_pkg::KIND_FRAME_END;
              res_item.frame_length = len_full;
              res_item.status       = slcd_pkg::ST_TOO_LONG;
              res_item.last         = 1'b1;
              phase_nxt             = PH_HUNT;
              sum_nxt               = 8'd0;
              length_nxt            = 16'd0;
            end else begin
              length_nxt = len_full;
              sum_nxt    = sum_add;
              phase_nxt  = (len_full == 16'd0) ? PH_CHECKSUM : PH_PAYLOAD;
            end
          end
          PH_PAYLOAD: begin
            res_valid             = 1'b1;
            res_item.payload_byte = b;
            sum_nxt               = sum_add;
            count_nxt             = count_r + CNT_W'(1);
            if ((16'(count_r) + 16'd1) == length_eff) begin
              phase_nxt = PH_CHECKSUM;
            end
          end
          PH_CHECKSUM: begin
            res_valid       = 1'b1;
            res_item.kind   = slcd_pkg::KIND_FRAME_END;
            res_item.status = (sum_eff == b) ? slcd_pkg::ST_OK : slcd_pkg::ST_BAD_SUM;
            res_item.last   = 1'b1;
            phase_nxt       = PH_HUNT;
            sum_nxt         = 8'd0;
            length_nxt      = 16'd0;
          end
          default: begin
            phase_nxt = PH_HUNT;
          end
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      gap_timeout_r <= slcd_pkg::GAP_TIMEOUT_RESET;
      s1_valid_r    <= 1'b0;
      phase_r       <= PH_HUNT;
      count_r       <= '0;
      length_r      <= 16'd0;
      sum_r         <= 8'd0;
      command_r     <= 8'd0;
      version_r     <= 8'd0;
      idle_r        <= 8'd0;
      out_valid_r   <= 1'b0;
    end else begin
      if (cfg_we) begin
        gap_timeout_r <= cfg_wdata;
      end
      if (in_ch.ready) begin
        s1_valid_r <= in_ch.valid;
      end
      phase_r   <= phase_nxt;
      count_r   <= count_nxt;
      length_r  <= length_nxt;
      sum_r     <= sum_nxt;
      command_r <= command_nxt;
      version_r <= version_nxt;
      idle_r    <= idle_nxt;
      if (res_valid) begin
        out_valid_r <= 1'b1;
      end else if (out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    if (in_ch.ready && in_ch.valid) begin
      s1_item_r <= in_ch.data;
    end
    if (res_valid) begin
      out_item_r <= res_item;
    end
  end

endmodule

// File: tb/sv/slcd_tb_pkg.sv
// Frame predictor and result scoreboard for the deframer testbench.
package slcd_tb_pkg;
  import slcd_pkg::*;

  localparam int unsigned FRAME_HEADER_BYTES = 6;

  class deframe_tracker;
    int unsigned max_payload;
    logic [7:0]  gap_timeout;
    int unsigned position;
    logic [15:0] length_field;
    logic [7:0]  running_sum;
    logic [7:0]  command_seen;
    logic [7:0]  version_seen;
    logic [7:0]  idle_ticks;
    out_item_t   pending_results[$];
    int unsigned failures;

    function new(int unsigned max_payload);
      this.max_payload = max_payload;
      failures = 0;
      gap_timeout = GAP_TIMEOUT_RESET;
      command_seen = 8'h00;
      version_seen = 8'h00;
      idle_ticks = 8'h00;
      restart_search();
    endfunction

    function void restart_search();
      position = 0;
      length_field = 16'h0000;
      running_sum = 8'h00;
    endfunction

    function void push_result(logic kind, logic [7:0] pbyte, logic [1:0] status);
      out_item_t r;
      r.kind = kind;
      r.payload_byte = pbyte;
      r.command = command_seen;
      r.version = version_seen;
      r.frame_length = length_field;
      r.status = status;
      r.last = (kind == KIND_FRAME_END);
      pending_results.push_back(r);
    endfunction

    // Notes one accepted transfer and queues the result it must cause, if any.
    function void absorb_item(in_item_t it);
      logic [7:0] b;
      b = it.rx_byte;
      if (it.mode == MODE_TICK) begin
        if (idle_ticks != IDLE_MAX) idle_ticks++;
        return;
      end
      if (idle_ticks > gap_timeout) restart_search();
      idle_ticks = 8'h00;

      if (position == 0) begin
        if (b == SYNC_FIRST) begin
          running_sum = b;
          position = 1;
        end
      end else if (position == 1) begin
        if (b == SYNC_SECOND) begin
          running_sum += b;
          position = 2;
        end else begin
          restart_search();
        end
      end else if (position < FRAME_HEADER_BYTES) begin
        if (position == 2) version_seen = b;
        else if (position == 3) command_seen = b;
        else if (position == 4) length_field = {b, 8'h00};
        else length_field[7:0] = b;
        running_sum += b;
        position++;
        if (position == FRAME_HEADER_BYTES && length_field > max_payload) begin
          push_result(KIND_FRAME_END, 8'h00, ST_TOO_LONG);
          restart_search();
        end
      end else if (position < FRAME_HEADER_BYTES + length_field) begin
        running_sum += b;
        position++;
        push_result(KIND_PAYLOAD, b, ST_OK);
      end else begin
        push_result(KIND_FRAME_END, 8'h00, (running_sum == b) ? ST_OK : ST_BAD_SUM);
        restart_search();
      end
    endfunction

    function void compare_field(string name, logic [15:0] want, logic [15:0] got);
      if (want !== got) begin
        failures++;
        $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
      end
    endfunction

    // Compares one accepted result with the oldest expectation.
    function void check_result(out_item_t got);
      out_item_t want;
      if (pending_results.size() == 0) begin
        failures++;
        $display("%0t: unexpected result, expected none, actual %h", $time, got);
        return;
      end
      want = pending_results.pop_front();
      compare_field("kind", want.kind, got.kind);
      compare_field("payload_byte", want.payload_byte, got.payload_byte);
      compare_field("command", want.command, got.command);
      compare_field("version", want.version, got.version);
      compare_field("frame_length", want.frame_length, got.frame_length);
      compare_field("status", want.status, got.status);
      compare_field("last", want.last, got.last);
    endfunction
  endclass

endpackage

// File: tb/sv/tb.sv
// Top-level testbench of the sync/length/checksum frame deframer.
//
// Frames, noise, broken headers and millisecond ticks are pushed through the
// input channel. Every accepted transfer is handed to a frame predictor that
// queues the payload and frame-end results it must cause; every accepted
// result is compared field by field with the oldest queued one. The run walks
// through several gap_timeout settings, including both extremes, and writes
// the register only while the block is drained.
module tb;
  import slcd_pkg::*;
  import slcd_tb_pkg::*;

  localparam int MAX_PAYLOAD      = 256;
  localparam int CYCLE_LIMIT      = 400000;
  localparam int LONG_HOLD_CYCLES = 300;
  localparam int ITEM_GOAL        = 1300;
  // Results pass through the input and result registers; allow a margin.
  localparam int PIPE_SETTLE      = 6;
  localparam int PHASE_COUNT      = 6;

  logic       clk;
  logic       rst_n;
  logic       cfg_we;
  logic [7:0] cfg_wdata;

  slcd_in_if  in_ch ();
  slcd_out_if out_ch ();

  deframe_tracker tracker;
  bit             idle_en;
  bit             hold_request;
  logic [7:0]     gap_now;
  int unsigned    items_sent;
  int unsigned    cycle_count = 0;

  sync_length_checksum_deframer #(
    .MAX_PAYLOAD(MAX_PAYLOAD)
  ) u_dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_ch    (in_ch),
    .out_ch   (out_ch),
    .cfg_we   (cfg_we),
    .cfg_wdata(cfg_wdata)
  );

  always begin
    clk = 1'b0;
    #10;
    clk = 1'b1;
    #10;
  end

  // A hung handshake must not keep the run alive forever.
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("[sync_length_checksum_deframer] ERROR");
      $finish;
    end
  end

  // Results are checked at the rising edge, where both handshake signals are
  // stable because they only change at the falling edge or through registers.
  always @(posedge clk) begin
    if (rst_n && out_ch.valid && out_ch.ready) tracker.check_result(out_ch.data);
  end

  // The receiver. Normally it stalls in short random bursts; when a long hold
  // is requested it keeps ready low for a long stretch, counted here, so the
  // result register fills and the block has to stall its input.
  initial begin
    int unsigned burst;
    burst = 0;
    out_ch.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_request) begin
        out_ch.ready <= 1'b0;
        repeat (LONG_HOLD_CYCLES) @(negedge clk);
        hold_request = 1'b0;
        out_ch.ready <= 1'b1;
      end else if (burst != 0) begin
        out_ch.ready <= 1'b0;
        burst--;
      end else if (idle_en && $urandom_range(0, 5) == 0) begin
        out_ch.ready <= 1'b0;
        burst = $urandom_range(0, 3);
      end else begin
        out_ch.ready <= 1'b1;
      end
    end
  end

  // Offers one item and returns at the rising edge at which it was accepted.
  // Valid stays high into the next item unless a random gap is inserted.
  task automatic send_item(input logic mode, input logic [7:0] value);
    in_item_t it;
    int unsigned n;
    it.mode = mode;
    it.rx_byte = value;
    @(negedge clk);
    if (idle_en && $urandom_range(0, 5) == 0) begin
      n = $urandom_range(1, 4);
      in_ch.valid <= 1'b0;
      repeat (n) @(negedge clk);
    end
    in_ch.valid <= 1'b1;
    in_ch.data <= it;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    tracker.absorb_item(it);
    items_sent++;
  endtask

  // Tick items carry a random byte, which the block must ignore.
  task automatic send_ticks(input int unsigned n);
    repeat (n) send_item(MODE_TICK, 8'($urandom));
  endtask

  // One byte that belongs to a frame. Now and then a few ticks come first,
  // never more than the gap allows, so the frame survives; the exact limit
  // is hit often when the gap is small.
  task automatic frame_byte(input logic [7:0] b);
    int unsigned n;
    if (gap_now != 0 && $urandom_range(0, 9) == 0) begin
      if (gap_now <= 20 && $urandom_range(0, 1) == 1) n = gap_now;
      else n = $urandom_range(1, (gap_now < 20) ? gap_now : 20);
      send_ticks(n);
    end
    send_item(MODE_BYTE, b);
  endtask

  // Sends a whole frame with random payload. A too-long length ends the frame
  // after its header. hold_ticks are inserted right after the sync pair, which
  // either tests the gap restart or, with the widest gap, idle saturation.
  task automatic send_frame(input logic [7:0] ver, input logic [7:0] cmd,
                            input logic [15:0] len, input bit corrupt_sum,
                            input int unsigned hold_ticks);
    logic [7:0] header [6];
    logic [7:0] sum;
    logic [7:0] b;
    header[0] = SYNC_FIRST;
    header[1] = SYNC_SECOND;
    header[2] = ver;
    header[3] = cmd;
    header[4] = len[15:8];
    header[5] = len[7:0];
    sum = 8'h00;
    for (int i = 0; i < 6; i++) begin
      if (i == 2 && hold_ticks != 0) send_ticks(hold_ticks);
      sum += header[i];
      frame_byte(header[i]);
    end
    if (len > MAX_PAYLOAD) return;
    for (int i = 0; i < len; i++) begin
      b = 8'($urandom);
      sum += b;
      frame_byte(b);
    end
    if (corrupt_sum) sum += 8'($urandom_range(1, 255));
    frame_byte(sum);
  endtask

  // Lowers valid, waits until every expected result has arrived, then lets
  // the pipeline settle so that items without a result have been handled.
  task automatic drain_results();
    @(negedge clk);
    in_ch.valid <= 1'b0;
    while (tracker.pending_results.size() != 0) @(posedge clk);
    repeat (PIPE_SETTLE) @(posedge clk);
  endtask

  task automatic write_gap(input logic [7:0] value);
    @(negedge clk);
    cfg_we <= 1'b1;
    cfg_wdata <= value;
    @(negedge clk);
    cfg_we <= 1'b0;
    tracker.gap_timeout = value;
    gap_now = value;
  endtask

  // Mostly well-formed frames with random content and lengths, the rest
  // truncated frames, broken sync pairs, stray bytes and tick bursts.
  task automatic random_traffic(input int unsigned goal);
    int unsigned pick;
    int unsigned k;
    logic [15:0] len;
    logic [7:0]  b;
    while (items_sent < goal) begin
      pick = $urandom_range(0, 99);
      if (pick < 70) begin
        k = $urandom_range(0, 99);
        if (k < 80) len = 16'($urandom_range(0, 12));
        else if (k < 90) len = 16'($urandom_range(13, MAX_PAYLOAD));
        else if (k < 95) len = 16'(MAX_PAYLOAD + $urandom_range(0, 1));
        else len = 16'($urandom);
        send_frame(8'($urandom), 8'($urandom), len, ($urandom_range(0, 4) == 0), 0);
      end else if (pick < 80) begin
        // A frame cut off by a silence longer than the gap.
        if (gap_now != IDLE_MAX) begin
          send_item(MODE_BYTE, SYNC_FIRST);
          send_item(MODE_BYTE, SYNC_SECOND);
          k = $urandom_range(0, 2);
          repeat (k) send_item(MODE_BYTE, 8'($urandom));
          send_ticks(gap_now + 1 + $urandom_range(0, 2));
        end
      end else if (pick < 88) begin
        b = 8'($urandom);
        if (b == SYNC_SECOND) b = SYNC_FIRST;
        send_item(MODE_BYTE, SYNC_FIRST);
        send_item(MODE_BYTE, b);
      end else if (pick < 95) begin
        k = $urandom_range(1, 4);
        repeat (k) send_item(MODE_BYTE, 8'($urandom));
      end else begin
        send_ticks($urandom_range(1, 10));
      end
    end
  endtask

  initial begin
    logic [7:0] gap_plan [PHASE_COUNT];
    rst_n = 1'b0;
    cfg_we = 1'b0;
    cfg_wdata = 8'h00;
    in_ch.valid = 1'b0;
    in_ch.data = '0;
    idle_en = 1'b1;
    hold_request = 1'b0;
    gap_now = GAP_TIMEOUT_RESET;
    items_sent = 0;
    tracker = new(MAX_PAYLOAD);

    repeat (6) @(negedge clk);
    rst_n <= 1'b1;

    // Directed part, with the reset gap. Stray bytes while hunting.
    send_item(MODE_BYTE, 8'h00);
    send_item(MODE_BYTE, 8'hFF);
    // A repeated first sync byte is a bad second sync and is not retried,
    // so the following 0xAA is just noise.
    send_item(MODE_BYTE, SYNC_FIRST);
    send_item(MODE_BYTE, SYNC_FIRST);
    send_item(MODE_BYTE, SYNC_SECOND);
    // Empty payload: the checksum follows the length directly.
    send_frame(8'hFF, 8'h00, 16'd0, 1'b0, 0);
    // One payload byte with a wrong checksum.
    send_frame(8'h00, 8'hFF, 16'd1, 1'b1, 0);
    // Lengths just above the limit and at the very top of the field.
    send_frame(8'hA5, 8'h5A, 16'(MAX_PAYLOAD + 1), 1'b0, 0);
    send_frame(8'h5A, 8'hA5, 16'hFFFF, 1'b0, 0);
    // A silence one tick longer than the gap restarts the search, so the
    // version byte after the sync pair is dropped as noise, not taken as the version.
    send_frame(8'h12, 8'h34, 16'd2, 1'b0, GAP_TIMEOUT_RESET + 1);
    send_frame(8'h81, 8'h7E, 16'd3, 1'b0, 0);
    drain_results();

    // The receiver holds off for a long stretch while a long frame keeps
    // coming, then the sender waits for every result before going on.
    hold_request = 1'b1;
    send_frame(8'h3C, 8'hC3, 16'd40, 1'b0, 0);
    drain_results();

    gap_plan[0] = GAP_TIMEOUT_RESET;
    gap_plan[1] = 8'd0;
    gap_plan[2] = IDLE_MAX;
    gap_plan[3] = 8'($urandom_range(2, 253));
    gap_plan[4] = 8'd1;
    gap_plan[5] = 8'd254;

    for (int p = 0; p < PHASE_COUNT; p++) begin
      if (p != 0) write_gap(gap_plan[p]);
      // One middle phase and the closing one run without any idling.
      idle_en = (p != 2 && p != PHASE_COUNT - 1);
      if (gap_now == 8'd0) begin
        // With no gap allowed, a single tick inside a frame restarts it.
        send_frame(8'($urandom), 8'($urandom), 16'd2, 1'b0, 1);
      end else if (gap_now == IDLE_MAX) begin
        // The idle counter saturates and the frame must still complete.
        send_frame(8'($urandom), 8'($urandom), 16'd4, 1'b0, 300);
      end
      random_traffic(ITEM_GOAL * (p + 1) / PHASE_COUNT);
      drain_results();
    end

    if (tracker.failures == 0) begin
      $display("[sync_length_checksum_deframer] OK");
    end else begin
      $display("[sync_length_checksum_deframer] ERROR");
    end
    $finish;
  end

endmodule

// File: sim.f
hw/rtl/slcd_pkg.sv
hw/rtl/slcd_in_if.sv
hw/rtl/slcd_out_if.sv
hw/rtl/sync_length_checksum_deframer.sv
tb/sv/slcd_tb_pkg.sv
tb/sv/tb.sv
